>>> sv/cils_pkg.sv
// Package for the content index with least-served selection.
// Holds request and response beat types and the opcode and status codes.
// No dependencies.
`timescale 1ns / 1ps

package cils_pkg;

    // Request opcodes.
    localparam logic [2:0] OP_REGISTER   = 3'd0;
    localparam logic [2:0] OP_DEREG_ONE  = 3'd1;
    localparam logic [2:0] OP_DEREG_ALL  = 3'd2;
    localparam logic [2:0] OP_SEARCH     = 3'd3;
    localparam logic [2:0] OP_LIST       = 3'd4;

    // Response status codes.
    localparam logic [2:0] ST_ACK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE  = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_HIT        = 3'd3;
    localparam logic [2:0] ST_LIST       = 3'd4;

    localparam logic [31:0] SERVED_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] peer_id;
        logic [31:0] content_id;
        logic [47:0] peer_address;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_peer;
        logic [31:0] found_content;
        logic [47:0] found_address;
        logic        last_result;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic eval;
        logic finish;
    } t_cmd;

endpackage

>>> sv/content_index_least_served.sv
// Top level of the content index with least-served selection.
// Joins the controller cils_ctrl and the datapath cils_dp; uses cils_pkg.
//
//   channel   direction  valid        stall         payload
//   request   in         i_in_valid   o_in_stall    i_in_data  (t_req)
//   response  out        o_out_valid  i_out_stall   o_out_data (t_rsp)
//
// Each request is accepted, then every slot is read in turn from the slot
// memory's single read port, the last read is evaluated and the request is
// finished. The scan and the finish step pause while a response beat waits in
// the output register.
// Reset clears all valid bits at once. Slot contents need no clearing.
`timescale 1ns / 1ps

module content_index_least_served #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cils_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cils_pkg::t_rsp o_out_data
);

    cils_pkg::t_cmd                  cmd;
    logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr;
    logic                            out_free;

    cils_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_out_free (out_free),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    cils_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .i_out_stall (i_out_stall),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sv/cils_ctrl.sv
// Controller for the content index: sequences accept, table scan and finish.
// Depends on cils_pkg.
`timescale 1ns / 1ps

module cils_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [2:0]                     i_opcode,
    input  logic                           i_out_free,
    output logic                           o_in_stall,
    output cils_pkg::t_cmd                 o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rd_addr
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_eval, n_eval;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_eval  = r_eval;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_opcode <= cils_pkg::OP_LIST) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SCAN;
                    n_addr       = '0;
                    n_eval       = 1'b0;
                end
            end
            S_SCAN: begin
                if (i_out_free) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.eval  = r_eval;
                    n_eval      = 1'b1;
                    n_addr      = r_addr + 1'b1;
                    if (r_addr == LAST_ADDR) begin
                        n_state = S_LAST;
                    end
                end
            end
            S_LAST: begin
                if (i_out_free) begin
                    o_cmd.eval = r_eval;
                    n_eval     = 1'b0;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_eval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_eval  <= n_eval;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_rd_addr  = r_addr;

endmodule

>>> sv/cils_dp.sv
// Datapath for the content index: slot memories, valid bits, scan evaluation
// and the output register. Depends on cils_pkg.
`timescale 1ns / 1ps

module cils_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cils_pkg::t_req                 i_in_data,
    input  cils_pkg::t_cmd                 i_cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    input  logic                           i_out_stall,
    output logic                           o_out_free,
    output logic                           o_out_valid,
    output cils_pkg::t_rsp                 o_out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Slot memories; contents are defined only once written.
    logic [31:0] mem_peer    [TABLE_DEPTH];
    logic [31:0] mem_content [TABLE_DEPTH];
    logic [47:0] mem_address [TABLE_DEPTH];
    logic [31:0] mem_served  [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] r_valid, n_valid;

    // Latched request.
    cils_pkg::t_req r_req;

    // Registered read port.
    logic [AW-1:0] r_rd_idx;
    logic [31:0]   r_rd_peer, r_rd_content, r_rd_served;
    logic [47:0]   r_rd_address;

    // Scan results.
    logic          r_dup, n_dup;
    logic          r_hit, n_hit;
    logic          r_have_free, n_have_free;
    logic [AW-1:0] r_free_idx, n_free_idx;
    logic          r_hold, n_hold;
    logic [AW-1:0] r_hold_idx, n_hold_idx;
    logic [31:0]   r_hold_peer, n_hold_peer;
    logic [31:0]   r_hold_content, n_hold_content;
    logic [47:0]   r_hold_address, n_hold_address;
    logic [31:0]   r_best, n_best;

    logic           r_out_valid, n_out_valid;
    cils_pkg::t_rsp r_out, n_out;

    // Memory write request.
    logic          w_en, w_full;
    logic [AW-1:0] w_addr;
    logic [31:0]   w_served;

    logic slot_v, peer_eq, content_eq;

    assign o_out_free = !r_out_valid || !i_out_stall;
    assign slot_v     = r_valid[r_rd_idx];
    assign peer_eq    = (r_rd_peer == r_req.peer_id);
    assign content_eq = (r_rd_content == r_req.content_id);

    // Slot evaluation during the scan and result build at the end.
    always_comb begin
        n_valid        = r_valid;
        n_dup          = r_dup;
        n_hit          = r_hit;
        n_have_free    = r_have_free;
        n_free_idx     = r_free_idx;
        n_hold         = r_hold;
        n_hold_idx     = r_hold_idx;
        n_hold_peer    = r_hold_peer;
        n_hold_content = r_hold_content;
        n_hold_address = r_hold_address;
        n_best         = r_best;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out          = r_out;
        w_en           = 1'b0;
        w_full         = 1'b0;
        w_addr         = r_free_idx;
        w_served       = '0;

        if (i_cmd.accept) begin
            n_dup       = 1'b0;
            n_hit       = 1'b0;
            n_have_free = 1'b0;
            n_hold      = 1'b0;
        end

        if (i_cmd.eval) begin
            case (r_req.opcode)
                cils_pkg::OP_REGISTER: begin
                    if (slot_v && peer_eq && content_eq) begin
                        n_dup = 1'b1;
                    end
                    if (!slot_v && !r_have_free) begin
                        n_have_free = 1'b1;
                        n_free_idx  = r_rd_idx;
                    end
                end
                cils_pkg::OP_DEREG_ONE: begin
                    if (slot_v && peer_eq && content_eq) begin
                        n_valid[r_rd_idx] = 1'b0;
                        n_hit             = 1'b1;
                    end
                end
                cils_pkg::OP_DEREG_ALL: begin
                    if (slot_v && peer_eq) begin
                        n_valid[r_rd_idx] = 1'b0;
                    end
                end
                cils_pkg::OP_SEARCH: begin
                    if (slot_v && content_eq && !peer_eq &&
                        (!r_hold || r_rd_served <= r_best)) begin
                        n_hold         = 1'b1;
                        n_hold_idx     = r_rd_idx;
                        n_best         = r_rd_served;
                        n_hold_peer    = r_rd_peer;
                        n_hold_content = r_rd_content;
                        n_hold_address = r_rd_address;
                    end
                end
                cils_pkg::OP_LIST: begin
                    // The held entry goes out once a later valid one shows
                    // that it is not the last.
                    if (slot_v) begin
                        if (r_hold) begin
                            n_out_valid = 1'b1;
                            n_out       = '{cils_pkg::ST_LIST, r_hold_peer,
                                            r_hold_content, 48'd0, 1'b0};
                        end
                        n_hold         = 1'b1;
                        n_hold_peer    = r_rd_peer;
                        n_hold_content = r_rd_content;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.finish) begin
            case (r_req.opcode)
                cils_pkg::OP_REGISTER: begin
                    n_out_valid = 1'b1;
                    if (r_dup) begin
                        n_out = '{cils_pkg::ST_DUPLICATE, 32'd0, 32'd0, 48'd0, 1'b1};
                    end else begin
                        n_out = '{cils_pkg::ST_ACK, r_req.peer_id, 32'd0, 48'd0, 1'b1};
                        if (r_have_free) begin
                            w_en                = 1'b1;
                            w_full              = 1'b1;
                            w_addr              = r_free_idx;
                            n_valid[r_free_idx] = 1'b1;
                        end
                    end
                end
                cils_pkg::OP_DEREG_ONE: begin
                    if (r_hit) begin
                        n_out_valid = 1'b1;
                        n_out = '{cils_pkg::ST_ACK, r_req.peer_id, 32'd0, 48'd0, 1'b1};
                    end
                end
                cils_pkg::OP_SEARCH: begin
                    n_out_valid = 1'b1;
                    if (r_hold) begin
                        n_out    = '{cils_pkg::ST_HIT, r_hold_peer, r_hold_content,
                                     r_hold_address, 1'b1};
                        w_en     = 1'b1;
                        w_addr   = r_hold_idx;
                        w_served = (r_best == cils_pkg::SERVED_MAX) ? r_best
                                                                     : r_best + 32'd1;
                    end else begin
                        n_out = '{cils_pkg::ST_NOT_FOUND, 32'd0, 32'd0, 48'd0, 1'b1};
                    end
                end
                cils_pkg::OP_LIST: begin
                    if (r_hold) begin
                        n_out_valid = 1'b1;
                        n_out = '{cils_pkg::ST_LIST, r_hold_peer, r_hold_content,
                                  48'd0, 1'b1};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Slot memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem_served[w_addr] <= w_served;
            if (w_full) begin
                mem_peer[w_addr]    <= r_req.peer_id;
                mem_content[w_addr] <= r_req.content_id;
                mem_address[w_addr] <= r_req.peer_address;
            end
        end
        if (i_cmd.rd_en) begin
            r_rd_idx     <= i_rd_addr;
            r_rd_peer    <= mem_peer[i_rd_addr];
            r_rd_content <= mem_content[i_rd_addr];
            r_rd_address <= mem_address[i_rd_addr];
            r_rd_served  <= mem_served[i_rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_data;
        end
        r_dup          <= n_dup;
        r_hit          <= n_hit;
        r_have_free    <= n_have_free;
        r_free_idx     <= n_free_idx;
        r_hold         <= n_hold;
        r_hold_idx     <= n_hold_idx;
        r_hold_peer    <= n_hold_peer;
        r_hold_content <= n_hold_content;
        r_hold_address <= n_hold_address;
        r_best         <= n_best;
        r_out          <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A waiting beat is never overwritten by a scan step.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval || i_cmd.finish) |-> (!r_out_valid || !i_out_stall))
        else $error("scan step while output beat is stalled");

    // A successful register occupies its slot.
    a_reg_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_req.opcode == cils_pkg::OP_REGISTER && !r_dup && r_have_free)
        |=> r_valid[$past(r_free_idx)])
        else $error("registered slot not marked valid");

    // Search and register always answer at the end of the scan.
    a_finish_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && (r_req.opcode == cils_pkg::OP_SEARCH ||
                          r_req.opcode == cils_pkg::OP_REGISTER)) |=> r_out_valid)
        else $error("missing response beat");

endmodule
